FILE: src/assert_macros.svh
// Assertion macros used by the checker file.
// Depends on nothing; the including module supplies clk and rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define LPAL_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("line program lookup assertion failed");

// Checked on every clock edge, reset included.
`define LPAL_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("line program lookup assertion failed");

`endif

FILE: src/lpal_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the line program address lookup.
// Used by the core, the divider and the checker.
package lpal_pkg;

  localparam int DEFAULT_ADDRESS_WIDTH = 64;

  localparam logic [1:0] ST_FOUND     = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_UNKNOWN   = 2'd2;

  localparam logic [2:0] REG_TARGET_ADDRESS  = 3'd0;
  localparam logic [2:0] REG_OPCODE_BASE     = 3'd1;
  localparam logic [2:0] REG_LINE_BASE       = 3'd2;
  localparam logic [2:0] REG_LINE_RANGE      = 3'd3;
  localparam logic [2:0] REG_MIN_INST_LENGTH = 3'd4;

  localparam logic [7:0] OP_EXTENDED         = 8'd0;
  localparam logic [7:0] OP_ADVANCE_PC       = 8'd2;
  localparam logic [7:0] OP_ADVANCE_LINE     = 8'd3;
  localparam logic [7:0] OP_SET_FILE         = 8'd4;
  localparam logic [7:0] OP_SET_COLUMN       = 8'd5;
  localparam logic [7:0] OP_CONST_ADVANCE    = 8'd8;
  localparam logic [7:0] OP_FIXED_ADVANCE    = 8'd9;
  localparam logic [7:0] OP_SET_ISA          = 8'd12;
  localparam logic [7:0] EXT_END_SEQUENCE    = 8'd1;
  localparam logic [7:0] EXT_SET_ADDRESS     = 8'd2;

  typedef struct packed {
    logic [7:0] program_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] source_line;
    logic [31:0] file_number;
  } out_beat_t;

  typedef struct packed {
    logic       start;
    logic [7:0] dividend;
    logic [7:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic       done;
    logic [7:0] quotient;
    logic [7:0] remainder;
  } div_rsp_t;

endpackage

FILE: src/lpal_div.sv
`timescale 1ns / 1ps
// Restoring divider for 8-bit operands, one quotient bit per cycle.
// Depends on lpal_pkg for the request and response structs.
module lpal_div
  import lpal_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [7:0] rem;
  logic [7:0] quo;
  logic [7:0] divisor;
  logic [3:0] count;
  logic       done_q;
  logic [8:0] shifted;
  logic [8:0] trial;

  assign shifted = {rem, quo[7]};
  assign trial   = shifted - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 4'd0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req.start) begin
        rem     <= 8'd0;
        quo     <= req.dividend;
        divisor <= req.divisor;
        count   <= 4'd8;
      end else if (count != 4'd0) begin
        if (shifted >= {1'b0, divisor}) begin
          rem <= trial[7:0];
          quo <= {quo[6:0], 1'b1};
        end else begin
          rem <= shifted[7:0];
          quo <= {quo[6:0], 1'b0};
        end
        count <= count - 4'd1;
        if (count == 4'd1) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp.done      = done_q;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

FILE: src/line_program_address_lookup_core.sv
`timescale 1ns / 1ps
// Top level of the line program address lookup.
// Depends on lpal_pkg and lpal_div.

// Takes one program byte per input beat and returns at most one result beat
// per program byte. Most bytes go from the idle state straight to the done
// state. An address advance by an operand passes through the multiply and move
// states, and the fixed-size address advance through the move state. A special
// opcode or the constant address advance runs the shared 8-bit divider and then
// multiplies and compares. A result that the output side has not yet taken
// holds the next byte back.
module line_program_address_lookup_core
  import lpal_pkg::*;
#(
  parameter int ADDRESS_WIDTH = DEFAULT_ADDRESS_WIDTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_beat_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_beat_t   out_data,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int AW = ADDRESS_WIDTH;

  typedef enum logic [2:0] {S_IDLE, S_DIV, S_MUL, S_MOVE, S_DONE} state_t;
  typedef enum logic [2:0] {PH_OPCODE, PH_LEB, PH_EXT_SUB, PH_EXT_BODY, PH_FIXED} phase_t;

  state_t      state;
  phase_t      phase;
  logic [63:0] target_address;
  logic [7:0]  special_base;
  logic [7:0]  line_floor;
  logic [7:0]  line_span;
  logic [7:0]  min_inst_length;

  logic [AW-1:0] address;
  logic [31:0]   line;
  logic [31:0]   file;
  logic [63:0]   acc;
  logic [6:0]    shift;
  logic [7:0]    pending;
  logic [31:0]   remaining;
  logic          done_flag;

  logic          special;
  logic [AW-1:0] mul_a;
  logic [AW-1:0] delta;
  logic [1:0]    result;
  logic          last_q;
  logic          active;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [7:0]    b;
  logic [7:0]    range_eff;
  logic [63:0]   leb_acc;
  logic [6:0]    leb_shift;
  logic [63:0]   leb_v;
  logic [63:0]   body_acc;
  logic [6:0]    body_shift;
  logic [63:0]   fix_acc;
  logic [AW+7:0] product;
  logic [AW-1:0] target_q;
  logic [AW-1:0] diff;
  logic          hit;
  logic          need_out;
  logic [31:0]   remaining_dec;

  assign b         = in_data.program_byte;
  assign range_eff = (line_span == 8'd0) ? 8'd1 : line_span;
  assign in_ready  = (state == S_IDLE);

  always_comb begin
    leb_acc   = acc;
    leb_shift = shift;
    if (shift < 7'd64) begin
      leb_acc   = acc | ({57'd0, b[6:0]} << shift[5:0]);
      leb_shift = shift + 7'd7;
    end
    leb_v = leb_acc;
    if (pending == OP_ADVANCE_LINE && leb_shift < 7'd64 && b[6]) begin
      leb_v = leb_acc | ({64{1'b1}} << leb_shift[5:0]);
    end
    body_acc   = acc;
    body_shift = shift;
    if (pending == EXT_SET_ADDRESS && shift < 7'd64) begin
      body_acc   = acc | ({56'd0, b} << shift[5:0]);
      body_shift = shift + 7'd8;
    end
    fix_acc = acc | ({56'd0, b} << (shift[3] ? 6'd8 : 6'd0));
  end

  assign remaining_dec = remaining - 32'd1;
  assign product       = mul_a * {{AW{1'b0}}, min_inst_length};
  assign target_q      = target_address[AW-1:0];
  assign diff          = target_q - address;
  assign hit           = (target_q >= address) && (diff < delta);
  assign need_out      = active && (result != 2'd0 || last_q);

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = b - special_base;
    div_req.divisor  = range_eff;
    if (state == S_IDLE && in_valid && !done_flag && phase == PH_OPCODE) begin
      if (b >= special_base) begin
        div_req.start = 1'b1;
      end else if (b == OP_CONST_ADVANCE) begin
        div_req.start    = 1'b1;
        div_req.dividend = 8'd255 - special_base;
      end
    end
  end

  lpal_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      phase           <= PH_OPCODE;
      target_address  <= 64'd0;
      special_base    <= 8'd13;
      line_floor      <= 8'hFB;
      line_span       <= 8'd14;
      min_inst_length <= 8'd1;
      address         <= '0;
      line            <= 32'd1;
      file            <= 32'd1;
      acc             <= 64'd0;
      shift           <= 7'd0;
      pending         <= 8'd0;
      remaining       <= 32'd0;
      done_flag       <= 1'b0;
      out_valid       <= 1'b0;
      result          <= 2'd0;
      last_q          <= 1'b0;
      active          <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_TARGET_ADDRESS:  target_address  <= cfg_data;
          REG_OPCODE_BASE:     special_base    <= cfg_data[7:0];
          REG_LINE_BASE:       line_floor      <= cfg_data[7:0];
          REG_LINE_RANGE:      line_span       <= cfg_data[7:0];
          REG_MIN_INST_LENGTH: min_inst_length <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            last_q <= in_data.last_byte;
            active <= !done_flag;
            result <= 2'd0;
            state  <= S_DONE;
            if (!done_flag) begin
              unique case (phase)
                PH_OPCODE: begin
                  acc   <= 64'd0;
                  shift <= 7'd0;
                  if (b >= special_base) begin
                    special <= 1'b1;
                    state   <= S_DIV;
                  end else if (b == OP_EXTENDED || b == OP_ADVANCE_PC ||
                               b == OP_ADVANCE_LINE || b == OP_SET_FILE ||
                               b == OP_SET_COLUMN || b == OP_SET_ISA) begin
                    pending <= b;
                    phase   <= PH_LEB;
                  end else if (b == OP_CONST_ADVANCE) begin
                    special <= 1'b0;
                    state   <= S_DIV;
                  end else if (b == OP_FIXED_ADVANCE) begin
                    phase <= PH_FIXED;
                  end else if (b > OP_SET_ISA) begin
                    result <= 2'd2;
                  end
                end
                PH_LEB: begin
                  acc   <= leb_acc;
                  shift <= leb_shift;
                  if (!b[7]) begin
                    acc   <= 64'd0;
                    shift <= 7'd0;
                    phase <= PH_OPCODE;
                    if (pending == OP_EXTENDED) begin
                      if (leb_v != 64'd0) begin
                        remaining <= (|leb_v[63:32]) ? 32'hFFFF_FFFF : leb_v[31:0];
                        phase     <= PH_EXT_SUB;
                      end
                    end else if (pending == OP_ADVANCE_PC) begin
                      mul_a <= leb_v[AW-1:0];
                      state <= S_MUL;
                    end else if (pending == OP_ADVANCE_LINE) begin
                      line <= line + leb_v[31:0];
                    end else if (pending == OP_SET_FILE) begin
                      file <= leb_v[31:0];
                    end
                  end
                end
                PH_EXT_SUB: begin
                  pending   <= b;
                  acc       <= 64'd0;
                  shift     <= 7'd0;
                  remaining <= remaining_dec;
                  if (remaining_dec == 32'd0) begin
                    phase <= PH_OPCODE;
                    if (b == EXT_END_SEQUENCE) begin
                      address <= '0;
                      line    <= 32'd1;
                      file    <= 32'd1;
                    end else if (b == EXT_SET_ADDRESS) begin
                      address <= '0;
                    end
                  end else begin
                    phase <= PH_EXT_BODY;
                  end
                end
                PH_EXT_BODY: begin
                  acc       <= body_acc;
                  shift     <= body_shift;
                  remaining <= remaining_dec;
                  if (remaining_dec == 32'd0) begin
                    acc   <= 64'd0;
                    shift <= 7'd0;
                    phase <= PH_OPCODE;
                    if (pending == EXT_END_SEQUENCE) begin
                      address <= '0;
                      line    <= 32'd1;
                      file    <= 32'd1;
                    end else if (pending == EXT_SET_ADDRESS) begin
                      address <= body_acc[AW-1:0];
                    end
                  end
                end
                PH_FIXED: begin
                  acc   <= fix_acc;
                  shift <= shift + 7'd8;
                  if (shift >= 7'd8) begin
                    acc   <= 64'd0;
                    shift <= 7'd0;
                    phase <= PH_OPCODE;
                    delta <= AW'(fix_acc[15:0]);
                    state <= S_MOVE;
                  end
                end
                default: ;
              endcase
            end
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            if (special) begin
              line <= line + {24'd0, div_rsp.remainder} + {{24{line_floor[7]}}, line_floor};
            end
            mul_a <= AW'(div_rsp.quotient);
            state <= S_MUL;
          end
        end
        S_MUL: begin
          delta <= product[AW-1:0];
          state <= S_MOVE;
        end
        S_MOVE: begin
          address <= address + delta;
          if (hit) begin
            result <= 2'd1;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!(need_out && out_valid && !out_ready)) begin
            if (need_out) begin
              out_valid <= 1'b1;
              if (result == 2'd1) begin
                out_data.status      <= ST_FOUND;
                out_data.source_line <= line;
                out_data.file_number <= file;
                done_flag            <= 1'b1;
              end else begin
                out_data.status      <= (result == 2'd2) ? ST_UNKNOWN : ST_NOT_FOUND;
                out_data.source_line <= 32'd0;
                out_data.file_number <= 32'd0;
                if (result == 2'd2) begin
                  done_flag <= 1'b1;
                end
              end
            end
            if (last_q) begin
              phase     <= PH_OPCODE;
              address   <= '0;
              line      <= 32'd1;
              file      <= 32'd1;
              acc       <= 64'd0;
              shift     <= 7'd0;
              pending   <= 8'd0;
              remaining <= 32'd0;
              done_flag <= 1'b0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: src/lpal_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the line program address lookup core and its bind.
// Depends on lpal_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lpal_checker
  import lpal_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_beat_t out_data
);

  logic miss_fields_zero;

  assign miss_fields_zero = (out_data.source_line == 32'd0) && (out_data.file_number == 32'd0);

  `LPAL_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data))
  `LPAL_ASSERT(a_busy_after_beat, in_valid && in_ready |=> !in_ready)
  `LPAL_ASSERT(a_status_code, out_valid |-> out_data.status != 2'd3)
  `LPAL_ASSERT(a_miss_zero, out_valid && out_data.status != ST_FOUND |-> miss_fields_zero)
  `LPAL_ASSERT_ALWAYS(a_reset_quiet, rst |=> !out_valid)

endmodule

bind line_program_address_lookup_core lpal_checker u_lpal_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

FILE: verif/line_program_address_lookup_core_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the line program address lookup core.
// Feeds random and directed line programs and compares against a built-in predictor.
// Depends on lpal_pkg and line_program_address_lookup_core.

module line_program_address_lookup_core_tb;
  import lpal_pkg::*;

  localparam int ADDR_W = 64;
  localparam int CYCLE_LIMIT = 900000;

  typedef enum logic [2:0] {
    PH_OPCODE, PH_LEB, PH_EXT_SUB, PH_EXT_BODY, PH_FIXED
  } phase_t;

  class line_scoreboard;
    logic [63:0] target;
    logic [7:0] op_base;
    logic [7:0] ln_base;
    logic [7:0] ln_range;
    logic [7:0] inst_len;
    phase_t phase;
    logic [63:0] addr;
    logic [31:0] line;
    logic [31:0] file;
    logic [63:0] acc;
    int unsigned shift;
    logic [7:0] pend;
    logic [31:0] remaining;
    bit done;
    out_beat_t pending_results[$];
    int errors;

    function void clear_program();
      phase = PH_OPCODE;
      addr = '0;
      line = 1;
      file = 1;
      acc = '0;
      shift = 0;
      pend = '0;
      remaining = '0;
      done = 0;
    endfunction

    function void reset_regs();
      target = '0;
      op_base = 8'd13;
      ln_base = 8'hFB;
      ln_range = 8'd14;
      inst_len = 8'd1;
      errors = 0;
      clear_program();
    endfunction

    function void write_reg(logic [2:0] idx, logic [63:0] val);
      case (idx)
        REG_TARGET_ADDRESS: target = val;
        REG_OPCODE_BASE: op_base = val[7:0];
        REG_LINE_BASE: ln_base = val[7:0];
        REG_LINE_RANGE: ln_range = val[7:0];
        REG_MIN_INST_LENGTH: inst_len = val[7:0];
        default: ;
      endcase
    endfunction

    function bit advance(logic [63:0] delta);
      bit hit;
      hit = (target >= addr) && ((target - addr) < delta);
      addr = addr + delta;
      return hit;
    endfunction

    function void end_extended();
      if (pend == EXT_END_SEQUENCE) begin
        addr = '0;
        line = 1;
        file = 1;
      end else if (pend == EXT_SET_ADDRESS) begin
        addr = acc;
      end
      acc = '0;
      shift = 0;
      phase = PH_OPCODE;
    endfunction

    function int decode_byte(logic [7:0] b);
      logic [31:0] range;
      logic [31:0] adj;
      logic [63:0] v;
      int r;
      range = (ln_range == 0) ? 32'd1 : {24'd0, ln_range};
      r = 0;
      case (phase)
        PH_OPCODE: begin
          acc = '0;
          shift = 0;
          if (b >= op_base) begin
            adj = {24'd0, b - op_base};
            line = line + (adj % range) + {{24{ln_base[7]}}, ln_base};
            if (advance(64'(adj / range) * inst_len)) r = 1;
          end else if (b == OP_EXTENDED || b == OP_ADVANCE_PC || b == OP_ADVANCE_LINE ||
                       b == OP_SET_FILE || b == OP_SET_COLUMN || b == OP_SET_ISA) begin
            pend = b;
            phase = PH_LEB;
          end else if (b == OP_CONST_ADVANCE) begin
            if (advance(64'(((32'd255 - op_base) / range) * inst_len))) r = 1;
          end else if (b == OP_FIXED_ADVANCE) begin
            phase = PH_FIXED;
          end else if (b > OP_SET_ISA) begin
            r = 2;
          end
        end
        PH_LEB: begin
          if (shift < 64) begin
            acc = acc | (64'(b[6:0]) << shift);
            shift = shift + 7;
          end
          if (!b[7]) begin
            v = acc;
            if (pend == OP_ADVANCE_LINE && shift < 64 && b[6]) v = v | ({64{1'b1}} << shift);
            acc = '0;
            shift = 0;
            phase = PH_OPCODE;
            case (pend)
              OP_EXTENDED: if (v != 0) begin
                remaining = (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
                phase = PH_EXT_SUB;
              end
              OP_ADVANCE_PC: if (advance(v * inst_len)) r = 1;
              OP_ADVANCE_LINE: line = line + v[31:0];
              OP_SET_FILE: file = v[31:0];
              default: ;
            endcase
          end
        end
        PH_EXT_SUB: begin
          pend = b;
          acc = '0;
          shift = 0;
          remaining = remaining - 1;
          if (remaining == 0) end_extended();
          else phase = PH_EXT_BODY;
        end
        PH_EXT_BODY: begin
          if (pend == EXT_SET_ADDRESS && shift < 64) begin
            acc = acc | (64'(b) << shift);
            shift = shift + 8;
          end
          remaining = remaining - 1;
          if (remaining == 0) end_extended();
        end
        default: begin
          acc = acc | (64'(b) << (shift & 8));
          shift = shift + 8;
          if (shift >= 16) begin
            v = acc & 64'hFFFF;
            acc = '0;
            shift = 0;
            phase = PH_OPCODE;
            if (advance(v)) r = 1;
          end
        end
      endcase
      return r;
    endfunction

    function void note_input(in_beat_t beat);
      out_beat_t res;
      int r;
      if (!done) begin
        r = decode_byte(beat.program_byte);
        if (r == 1) begin
          res.status = ST_FOUND;
          res.source_line = line;
          res.file_number = file;
          pending_results.push_back(res);
          done = 1;
        end else if (r == 2) begin
          res = '0;
          res.status = ST_UNKNOWN;
          pending_results.push_back(res);
          done = 1;
        end else if (beat.last_byte) begin
          res = '0;
          res.status = ST_NOT_FOUND;
          pending_results.push_back(res);
        end
      end
      if (beat.last_byte) clear_program();
    endfunction

    function void check_result(out_beat_t got);
      out_beat_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        errors++;
      end
      if (got.source_line !== want.source_line) begin
        $display("%0t: source_line expected %0d actual %0d", $time, want.source_line,
                 got.source_line);
        errors++;
      end
      if (got.file_number !== want.file_number) begin
        $display("%0t: file_number expected %0d actual %0d", $time, want.file_number,
                 got.file_number);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  in_beat_t in_data = '0;
  logic out_valid;
  logic out_ready = 0;
  out_beat_t out_data;
  logic cfg_write = 0;
  logic [2:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  line_scoreboard lookup_sb;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_off = 0;
  int cycle_count = 0;
  byte unsigned byte_stream[$];

  always #2 clk = ~clk;

  line_program_address_lookup_core #(.ADDRESS_WIDTH(ADDR_W)) DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) lookup_sb.check_result(out_data);
    if (rst) begin
      out_ready <= 0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    in_beat_t beat;
    int idle;
    idle = 0;
    while ($urandom_range(99) < send_idle_pct) idle++;
    beat.program_byte = b;
    beat.last_byte = last;
    if (idle > 0) begin
      in_valid <= 0;
      repeat (idle) @(posedge clk);
    end
    in_valid <= 1;
    in_data <= beat;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    lookup_sb.note_input(beat);
  endtask

  task automatic send_program();
    for (int i = 0; i < byte_stream.size(); i++)
      send_byte(byte_stream[i], i == byte_stream.size() - 1);
    byte_stream.delete();
  endtask

  task automatic drain();
    in_valid <= 0;
    while (lookup_sb.pending_results.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [2:0] idx, input logic [63:0] val);
    cfg_write <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    lookup_sb.write_reg(idx, val);
    cfg_write <= 0;
    @(posedge clk);
  endtask

  task automatic push_uleb(input logic [63:0] v);
    do begin
      byte_stream.push_back({(v >> 7) != 0, v[6:0]});
      v = v >> 7;
    end while (v != 0);
  endtask

  task automatic push_random_op();
    int kind;
    int n;
    kind = $urandom_range(11);
    case (kind)
      0, 1, 2: byte_stream.push_back(8'($urandom_range(255, lookup_sb.op_base)));
      3: begin
        byte_stream.push_back(OP_ADVANCE_PC);
        push_uleb(64'($urandom_range(40)));
      end
      4: begin
        byte_stream.push_back(OP_ADVANCE_LINE);
        n = $urandom_range(3) + 1;
        repeat (n - 1) byte_stream.push_back(8'($urandom_range(255, 128)));
        byte_stream.push_back(8'($urandom_range(127)));
      end
      5: begin
        byte_stream.push_back(OP_SET_FILE);
        push_uleb(64'($urandom));
      end
      6: begin
        byte_stream.push_back(OP_FIXED_ADVANCE);
        byte_stream.push_back(8'($urandom_range(255)));
        byte_stream.push_back(8'($urandom_range(3)));
      end
      7: byte_stream.push_back(OP_CONST_ADVANCE);
      8: begin
        byte_stream.push_back(OP_EXTENDED);
        n = $urandom_range(9);
        push_uleb(64'(n));
        if (n > 0) byte_stream.push_back(EXT_SET_ADDRESS);
        repeat ((n > 0) ? n - 1 : 0) byte_stream.push_back(8'($urandom_range(255)));
      end
      9: begin
        byte_stream.push_back(OP_EXTENDED);
        push_uleb(64'd1);
        byte_stream.push_back(EXT_END_SEQUENCE);
      end
      10: begin
        byte_stream.push_back(OP_EXTENDED);
        n = $urandom_range(4) + 1;
        push_uleb(64'(n));
        repeat (n) byte_stream.push_back(8'($urandom_range(255)));
      end
      default: byte_stream.push_back(8'($urandom_range(255)));
    endcase
  endtask

  task automatic random_phase(input int programs);
    int len;
    for (int p = 0; p < programs; p++) begin
      len = $urandom_range(6) + 1;
      if ($urandom_range(3) == 0) begin
        byte_stream.push_back(OP_EXTENDED);
        push_uleb(64'd9);
        byte_stream.push_back(EXT_SET_ADDRESS);
        repeat (8) byte_stream.push_back(8'($urandom_range(255)));
      end
      repeat (len) push_random_op();
      send_program();
    end
  endtask

  initial begin
    lookup_sb = new();
    lookup_sb.reset_regs();
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    write_cfg(REG_TARGET_ADDRESS, 64'd5);
    byte_stream = '{8'd255, 8'd13, 8'd1, 8'd6, 8'd7, 8'd10, 8'd11};
    send_program();
    byte_stream = '{8'd5, 8'd255, 8'd12, 8'd128, 8'd0, 8'd8, 8'd8};
    send_program();
    byte_stream = '{8'd0, 8'd0, 8'd3, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                    8'hFF, 8'hFF, 8'h7F, 8'd9, 8'd4, 8'd0};
    send_program();
    byte_stream = '{8'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'd7, 8'd1};
    send_program();
    byte_stream = '{8'd13, 8'd0, 8'd0};
    send_program();
    drain();
    write_cfg(REG_TARGET_ADDRESS, 64'hFFFF_FFFF_FFFF_FFFF);
    write_cfg(REG_OPCODE_BASE, 64'd1);
    write_cfg(REG_LINE_BASE, 64'h80);
    write_cfg(REG_LINE_RANGE, 64'd0);
    write_cfg(REG_MIN_INST_LENGTH, 64'd255);
    byte_stream = '{8'd0, 8'd9, 8'd2, 8'hF0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                    8'hFF, 8'd2};
    send_program();
    drain();

    send_idle_pct = 11;
    recv_idle_pct = 53;
    for (int s = 0; s < 6; s++) begin
      if (s == 3) begin
        send_idle_pct = 53;
        recv_idle_pct = 11;
      end
      if (s == 5) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_cfg(REG_TARGET_ADDRESS, 64'($urandom_range(600)));
      write_cfg(REG_OPCODE_BASE, (s == 4) ? 64'd255 : 64'($urandom_range(40, 10)));
      write_cfg(REG_LINE_BASE, (s == 1) ? 64'h7F : 64'($urandom_range(255)));
      write_cfg(REG_LINE_RANGE, (s == 2) ? 64'd255 : 64'($urandom_range(16, 1)));
      write_cfg(REG_MIN_INST_LENGTH, (s == 3) ? 64'd255 : 64'($urandom_range(4, 1)));
      if (s == 1) hold_off = 400;
      random_phase(8);
      drain();
    end

    if (lookup_sb.errors == 0 && lookup_sb.pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
